// ===== rtl/quaternion_vector_rotate_top_assert.svh =====
// Assertion macros for the quaternion vector rotator.
// Each macro takes a label, a clock, a reset and two expressions.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qvr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qvr assertion failed");

`else

`define QVR_ASSERT_SAME(label, clk, rst, ante, cons)
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/qvr_pkg.sv =====
package qvr_pkg;

  // Default number of fraction bits in the quaternion components.
  localparam int QUAT_FRAC_BITS_DEF = 30;

  // Widths of the intermediate quaternion t = q * (0, v) and of the final sums.
  localparam int T_W    = 66;
  localparam int PROD_W = 98;
  localparam int ACC_W  = 100;

  // Split point of the wide multiply into two narrower partial products.
  localparam int SPLIT = 33;

  // Configuration register indexes.
  localparam logic [1:0] REG_QUAT_W = 2'd0;
  localparam logic [1:0] REG_QUAT_X = 2'd1;
  localparam logic [1:0] REG_QUAT_Y = 2'd2;
  localparam logic [1:0] REG_QUAT_Z = 2'd3;

  // Term signs of the second Hamilton product, bit k set means term k is subtracted.
  localparam logic [3:0] TERM_NEG [3] = '{4'b0101, 4'b1001, 4'b0011};

  // Limits of a 32-bit signed result in the accumulator width.
  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  // Load strobes for the two registers of a split multiplier.
  typedef struct packed {
    logic ld_part;
    logic ld_prod;
  } mul_en_t;

endpackage

// ===== rtl/qvr_mul_split.sv =====
module qvr_mul_split (
  input  logic                              clk,
  input  qvr_pkg::mul_en_t                  en,
  input  logic signed [qvr_pkg::T_W-1:0]    a,
  input  logic signed [31:0]                b,
  output logic signed [qvr_pkg::PROD_W-1:0] prod
);
  import qvr_pkg::*;

  localparam int LO_W = SPLIT + 33;
  localparam int HI_W = T_W - SPLIT + 32;

  logic signed [LO_W-1:0] part_lo;
  logic signed [HI_W-1:0] part_hi;

  // First register: low half (unsigned) and high half (signed) times b.
  always_ff @(posedge clk) begin
    if (en.ld_part) begin
      part_lo <= LO_W'($signed({1'b0, a[SPLIT-1:0]})) * LO_W'(b);
      part_hi <= HI_W'($signed(a[T_W-1:SPLIT])) * HI_W'(b);
    end
  end

  // Second register: recombine the partial products.
  always_ff @(posedge clk) begin
    if (en.ld_prod) begin
      prod <= (PROD_W'(part_hi) <<< SPLIT) + PROD_W'(part_lo);
    end
  end

endmodule

// ===== rtl/quaternion_vector_rotate_top.sv =====
// Quaternion vector rotator: r = q * (0, v) * conj(q), rounded and saturated.
// Pipeline: seven register stages; an accepted item moves through them in order
// to the output register.
// Throughput: one item per cycle; each stage holds while the next is full,
// so bubbles close up and an item is taken while a result waits.
// Reset (rst, synchronous) empties the pipeline and sets q to (1.0, 0, 0, 0).
`include "quaternion_vector_rotate_top_assert.svh"

module quaternion_vector_rotate_top #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  // Input vectors.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  // Rotated vectors.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // rot_x [31:0], rot_y [63:32], rot_z [95:64]
  output logic [0:0]  m_tuser    // clipped [0]
);
  import qvr_pkg::*;

  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);

  logic signed [31:0] quat [4];

  logic en1, en2, en3, en4, en5, en6, en7;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [31:0] vec_x, vec_y, vec_z;
  logic signed [63:0] p1 [12];
  logic signed [T_W-1:0] t2 [4];
  logic signed [PROD_W-1:0] m4 [3][4];
  logic signed [ACC_W-1:0] pa5 [3];
  logic signed [ACC_W-1:0] pb5 [3];
  logic signed [ACC_W-1:0] acc6 [3];
  logic signed [ACC_W-1:0] shifted [3];
  logic [31:0] rot_next [3];
  logic [2:0] sat_next;
  mul_en_t mul_en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat[0] <= 32'(1) << QUAT_FRAC_BITS;
      quat[1] <= '0;
      quat[2] <= '0;
      quat[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_QUAT_W: quat[0] <= cfg_data;
        REG_QUAT_X: quat[1] <= cfg_data;
        REG_QUAT_Y: quat[2] <= cfg_data;
        REG_QUAT_Z: quat[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  assign en7 = !m_tvalid || m_tready;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) m_tvalid <= v6;
    end
  end

  assign vec_x = s_tdata[31:0];
  assign vec_y = s_tdata[63:32];
  assign vec_z = s_tdata[95:64];

  // Stage 1: the twelve products of the first Hamilton product.
  always_ff @(posedge clk) begin
    if (en1) begin
      p1[0]  <= 64'(quat[1]) * 64'(vec_x);
      p1[1]  <= 64'(quat[2]) * 64'(vec_y);
      p1[2]  <= 64'(quat[3]) * 64'(vec_z);
      p1[3]  <= 64'(quat[0]) * 64'(vec_x);
      p1[4]  <= 64'(quat[2]) * 64'(vec_z);
      p1[5]  <= 64'(quat[3]) * 64'(vec_y);
      p1[6]  <= 64'(quat[0]) * 64'(vec_y);
      p1[7]  <= 64'(quat[1]) * 64'(vec_z);
      p1[8]  <= 64'(quat[3]) * 64'(vec_x);
      p1[9]  <= 64'(quat[0]) * 64'(vec_z);
      p1[10] <= 64'(quat[1]) * 64'(vec_y);
      p1[11] <= 64'(quat[2]) * 64'(vec_x);
    end
  end

  // Stage 2: t = q * (0, v).
  always_ff @(posedge clk) begin
    if (en2) begin
      t2[0] <= -(T_W'(p1[0]) + T_W'(p1[1]) + T_W'(p1[2]));
      t2[1] <= T_W'(p1[3]) + T_W'(p1[4]) - T_W'(p1[5]);
      t2[2] <= T_W'(p1[6]) - T_W'(p1[7]) + T_W'(p1[8]);
      t2[3] <= T_W'(p1[9]) + T_W'(p1[10]) - T_W'(p1[11]);
    end
  end

  // Stages 3 and 4: the products of t with the conjugate, as split multiplies.
  assign mul_en.ld_part = en3;
  assign mul_en.ld_prod = en4;

  for (genvar o = 0; o < 3; o++) begin : g_out
    for (genvar k = 0; k < 4; k++) begin : g_term
      localparam int QI = k ^ (o + 1);
      qvr_mul_split u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (t2[k]),
        .b    (quat[QI]),
        .prod (m4[o][k])
      );
    end
  end

  // Stage 5: pairwise signed sums of the four terms of each component.
  always_ff @(posedge clk) begin
    if (en5) begin
      for (int o = 0; o < 3; o++) begin
        pa5[o] <= (TERM_NEG[o][0] ? -ACC_W'(m4[o][0]) : ACC_W'(m4[o][0]))
                + (TERM_NEG[o][1] ? -ACC_W'(m4[o][1]) : ACC_W'(m4[o][1]));
        pb5[o] <= (TERM_NEG[o][2] ? -ACC_W'(m4[o][2]) : ACC_W'(m4[o][2]))
                + (TERM_NEG[o][3] ? -ACC_W'(m4[o][3]) : ACC_W'(m4[o][3]));
      end
    end
  end

  // Stage 6: full sum with the rounding offset.
  always_ff @(posedge clk) begin
    if (en6) begin
      for (int o = 0; o < 3; o++) begin
        acc6[o] <= pa5[o] + pb5[o] + HALF;
      end
    end
  end

  // Drop the fraction bits and saturate each component to 32 bits.
  always_comb begin
    for (int o = 0; o < 3; o++) begin
      shifted[o] = acc6[o] >>> SHIFT;
      if (shifted[o] > SAT_MAX) begin
        rot_next[o] = 32'h7FFF_FFFF;
        sat_next[o] = 1'b1;
      end else if (shifted[o] < SAT_MIN) begin
        rot_next[o] = 32'h8000_0000;
        sat_next[o] = 1'b1;
      end else begin
        rot_next[o] = shifted[o][31:0];
        sat_next[o] = 1'b0;
      end
    end
  end

  // Stage 7: output register.
  always_ff @(posedge clk) begin
    if (en7) begin
      m_tdata <= {rot_next[2], rot_next[1], rot_next[0]};
      m_tuser <= |sat_next;
    end
  end

  // A clipped result carries at least one limit value.
  `QVR_ASSERT_SAME(a_clip_limit, clk, rst, m_tvalid && m_tuser[0],
    (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000) ||
    (m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000) ||
    (m_tdata[95:64] == 32'h7FFF_FFFF) || (m_tdata[95:64] == 32'h8000_0000))
  // Input ready drops only when every stage is occupied.
  `QVR_ASSERT_SAME(a_full_stall, clk, rst, !s_tready,
    v1 && v2 && v3 && v4 && v5 && v6 && m_tvalid && !m_tready)
  // An accepted item is in the first stage in the next cycle.
  `QVR_ASSERT_NEXT(a_accept_lands, clk, rst, s_tvalid && s_tready, v1)

endmodule
